@@ hw/rtl/tfj_pkg.sv @@
// ----------------------------------------------------------------------------
// tfj_pkg: shared types and constants of the text full justifier
// Character codes, configuration width and the control words that pass
// between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tfj_pkg;

  // Width of the line_width configuration register
  localparam int CFG_W = 5;
  // Width of one text character
  localparam int BYTE_W = 8;
  // Default capacity of the line and word stores
  localparam int LINE_MAX_DEF = 31;
  // Reset value of line_width
  localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd31;

  // Character codes
  localparam logic [BYTE_W-1:0] SEP_CHAR = 8'd32;
  localparam logic [BYTE_W-1:0] NL_CHAR  = 8'd10;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // One output word handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              word_cut;
  } emit_t;

endpackage

`default_nettype wire

@@ hw/rtl/text_full_justifier_core.sv @@
// Text full justifier: one character in, justified lines out.
// A letter is stored directly; a separator starts placing the finished word, and
//   when a line goes out, its characters are sent one by one, each gap waiting
//   for its share from the shared iterative divider.
// Input is not ready while a word is placed or a line is sent.
// Reset: rst (synchronous) clears the sequencer, counts and line_width to 31.
// ----------------------------------------------------------------------------
// text_full_justifier_core: top level of the text full justifier
// Holds the width register and the output register, and ties the sequencer
// to the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module text_full_justifier_core #(
  parameter int LINE_MAX = tfj_pkg::LINE_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration: line_width
  input  wire logic                        cfg_we,
  input  wire logic [tfj_pkg::CFG_W-1:0]   cfg_wdata,
  // Input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] text_byte
  input  wire logic                        s_axis_tlast,   // end_of_text
  // Output stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [7:0]                  m_axis_tdata,   // [7:0] out_byte
  output logic                             m_axis_tlast,   // last
  output logic                             m_axis_tuser    // [0] word_cut
);
  import tfj_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam logic [CFG_W-1:0] LMAX_CFG = CFG_W'(LINE_MAX);

  logic [CFG_W-1:0] line_width;
  logic [CW-1:0]    eff_width;
  logic             emit_ok;
  emit_t            emit;
  logic             div_start;
  logic [CW-1:0]    div_dividend;
  logic [CW-1:0]    div_divisor;
  div_sts_t         div_sts;
  logic [CW-1:0]    div_quot;

  // Width register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      line_width <= cfg_wdata;
    end
  end

  // Saturate the width into 1..LINE_MAX
  always_comb begin
    if (line_width == '0) begin
      eff_width = CW'(1);
    end else if (line_width > LMAX_CFG) begin
      eff_width = CW'(LINE_MAX);
    end else begin
      eff_width = CW'(line_width);
    end
  end

  tfj_ctrl #(
    .LINE_MAX (LINE_MAX)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_byte      (s_axis_tdata),
    .in_end       (s_axis_tlast),
    .eff_width    (eff_width),
    .emit_ok      (emit_ok),
    .emit         (emit),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_sts      (div_sts),
    .div_quot     (div_quot)
  );

  tfj_div #(
    .W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // Output register: load a new word when the slot is free or being drained
  assign emit_ok = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_axis_tdata <= emit.out_byte;
      m_axis_tlast <= emit.last;
      m_axis_tuser <= emit.word_cut;
    end
  end

  // Divider is never restarted while it works
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // A done pulse always follows a busy cycle
  a_div_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> $past(div_sts.busy))
    else $error("divider done without work");

  // No output while a character is taken in
  a_accept_no_emit: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !emit.valid)
    else $error("output word during input accept");

  // A word is only loaded into a free or draining output register
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output word overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/tfj_div.sv @@
// ----------------------------------------------------------------------------
// tfj_div: iterative restoring divider
// Produces one quotient bit per cycle; the quotient is valid while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tfj_div #(
  parameter int W = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [W-1:0]    dividend,
  input  wire logic [W-1:0]    divisor,
  output tfj_pkg::div_sts_t    sts,
  output logic      [W-1:0]    quot
);
  import tfj_pkg::*;

  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     acc;
  logic [W-1:0]     qreg;
  logic [W-1:0]     dsr;

  logic [W:0]       trial;
  logic             fits;

  // Trial subtraction for the current quotient bit
  always_comb begin
    trial = {acc, qreg[W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  // Control: busy from start until the last quotient bit is shifted in, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      acc  <= '0;
      qreg <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      cnt  <= cnt + CNT_W'(1);
      acc  <= fits ? W'(trial - {1'b0, dsr}) : trial[W-1:0];
      qreg <= {qreg[W-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quot     = qreg;

endmodule

`default_nettype wire

@@ hw/rtl/tfj_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfj_ctrl: word packing and line emission sequencer
// Collects letters, packs words into the line store and sends justified lines
// one character per cycle unless stalled, using the shared divider for gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tfj_ctrl #(
  parameter  int LINE_MAX = tfj_pkg::LINE_MAX_DEF,
  localparam int CW       = $clog2(LINE_MAX + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tfj_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                         in_end,
  input  wire logic [CW-1:0]                eff_width,
  input  wire logic                         emit_ok,
  output tfj_pkg::emit_t                    emit,
  output logic                              div_start,
  output logic      [CW-1:0]                div_dividend,
  output logic      [CW-1:0]                div_divisor,
  input  tfj_pkg::div_sts_t                 div_sts,
  input  wire logic [CW-1:0]                div_quot
);
  import tfj_pkg::*;

  localparam int IW = $clog2(LINE_MAX);
  localparam logic [CW-1:0] LMAX = CW'(LINE_MAX);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PLACE = 9'b000000010,
    S_COPY  = 9'b000000100,
    S_AFTER = 9'b000001000,
    S_SEND  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_SPACE = 9'b001000000,
    S_NL    = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE = 2'd0,
    RET_COPY = 2'd1,
    RET_WORD = 2'd2
  } ret_t;

  state_t            state;
  ret_t              ret;

  logic [BYTE_W-1:0] word_store [LINE_MAX];
  logic [BYTE_W-1:0] line_store [LINE_MAX];

  logic [CW-1:0]     word_length;
  logic              word_ovf;
  logic [CW-1:0]     wc;
  logic [CW-1:0]     letters;
  logic              end_lat;
  logic [CW-1:0]     wlen;

  logic [CW-1:0]     idx;
  logic [CW-1:0]     slen;
  logic [CW-1:0]     slack;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     sp;
  logic              s_word;
  logic              s_last;
  logic [CW-1:0]     cpos;
  logic              need_sep;

  logic              wl_lt_w;
  logic [CW-1:0]     plen;
  logic              pcut;
  logic [CW+1:0]     fit_sum;
  logic              overfull;
  logic [CW-1:0]     gaps;
  logic [CW-1:0]     line_len;
  logic [CW-1:0]     base;
  logic [CW-1:0]     line_slack;
  logic [BYTE_W-1:0] cur_byte;
  logic              in_range;
  logic              is_gap;

  // Word placement decisions
  always_comb begin
    wl_lt_w  = word_length < eff_width;
    plen     = wl_lt_w ? word_length : eff_width;
    pcut     = word_ovf || (word_length > eff_width);
    fit_sum  = {2'b00, letters} + {2'b00, wc} + {2'b00, plen};
    overfull = (wc != '0) && (fit_sum > {2'b00, eff_width});
  end

  // Line send setup: length and starting slack
  always_comb begin
    gaps       = wc - CW'(1);
    line_len   = letters + gaps;
    base       = (eff_width > letters) ? eff_width - letters : '0;
    line_slack = (base < gaps) ? gaps : base;
  end

  // Read the character under the send pointer
  always_comb begin
    in_range = idx < slen;
    cur_byte = '0;
    if (idx < LMAX) begin
      cur_byte = s_word ? word_store[idx[IW-1:0]] : line_store[idx[IW-1:0]];
    end
    is_gap = (cur_byte == SEP_CHAR) && (rem != '0);
  end

  // Divider request at a gap
  always_comb begin
    div_start    = (state == S_SEND) && in_range && is_gap;
    div_dividend = slack;
    div_divisor  = rem;
  end

  // Output word
  always_comb begin
    emit.valid    = 1'b0;
    emit.out_byte = cur_byte;
    emit.last     = 1'b0;
    emit.word_cut = s_word;
    unique case (state)
      S_SEND: begin
        emit.valid = emit_ok && in_range && !is_gap;
      end
      S_SPACE: begin
        emit.valid    = emit_ok && (sp != '0);
        emit.out_byte = SEP_CHAR;
      end
      S_NL: begin
        emit.valid    = emit_ok;
        emit.out_byte = NL_CHAR;
        emit.last     = s_last;
      end
      default: begin
        emit.valid = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // Stores: written one entry per cycle, never cleared
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid && (in_byte != SEP_CHAR) && (word_length < LMAX)) begin
      word_store[word_length[IW-1:0]] <= in_byte;
    end
    if ((state == S_COPY) && (cpos < LMAX)) begin
      if (need_sep) begin
        line_store[cpos[IW-1:0]] <= SEP_CHAR;
      end else if (idx < wlen) begin
        line_store[cpos[IW-1:0]] <= word_store[idx[IW-1:0]];
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= RET_IDLE;
      word_length <= '0;
      word_ovf    <= 1'b0;
      wc          <= '0;
      letters     <= '0;
      end_lat     <= 1'b0;
    end else begin
      unique case (state)
        // Take one character
        S_IDLE: begin
          if (in_valid) begin
            end_lat <= in_end;
            if (in_byte != SEP_CHAR) begin
              if (word_length < LMAX) begin
                word_length <= word_length + CW'(1);
              end else begin
                word_ovf <= 1'b1;
              end
            end
            if ((in_byte == SEP_CHAR) || in_end) begin
              state <= S_PLACE;
            end
          end
        end

        // Decide where the finished word goes
        S_PLACE: begin
          wlen <= plen;
          if (word_length == '0) begin
            state <= S_AFTER;
          end else if (pcut) begin
            idx   <= '0;
            state <= S_SEND;
            if (wc != '0) begin
              slen   <= line_len;
              slack  <= line_slack;
              rem    <= gaps;
              s_word <= 1'b0;
              s_last <= 1'b0;
              ret    <= RET_WORD;
            end else begin
              slen   <= plen;
              slack  <= '0;
              rem    <= '0;
              s_word <= 1'b1;
              s_last <= 1'b1;
              ret    <= RET_IDLE;
            end
          end else if (overfull) begin
            idx    <= '0;
            slen   <= line_len;
            slack  <= line_slack;
            rem    <= gaps;
            s_word <= 1'b0;
            s_last <= !end_lat;
            ret    <= RET_COPY;
            state  <= S_SEND;
          end else begin
            idx      <= '0;
            cpos     <= (wc != '0) ? line_len + CW'(1) - CW'(1) : '0;
            need_sep <= (wc != '0);
            state    <= S_COPY;
          end
        end

        // Append separator and letters to the line store
        S_COPY: begin
          if (need_sep) begin
            need_sep <= 1'b0;
            cpos     <= cpos + CW'(1);
          end else if (idx < wlen) begin
            idx  <= idx + CW'(1);
            cpos <= cpos + CW'(1);
          end else begin
            wc          <= wc + CW'(1);
            letters     <= letters + wlen;
            word_length <= '0;
            word_ovf    <= 1'b0;
            state       <= S_AFTER;
          end
        end

        // Flush the pending line at end of text, else wait for the next character
        S_AFTER: begin
          if (end_lat && (wc != '0)) begin
            idx    <= '0;
            slen   <= line_len;
            slack  <= line_slack;
            rem    <= gaps;
            s_word <= 1'b0;
            s_last <= 1'b1;
            ret    <= RET_IDLE;
            state  <= S_SEND;
          end else begin
            state <= S_IDLE;
          end
        end

        // Send characters; a gap asks the divider for its share
        S_SEND: begin
          if (!in_range) begin
            state <= S_NL;
          end else if (is_gap) begin
            state <= S_DIV;
          end else if (emit_ok) begin
            idx <= idx + CW'(1);
          end
        end

        // Wait for the gap share
        S_DIV: begin
          if (div_sts.done) begin
            sp    <= div_quot;
            slack <= slack - div_quot;
            rem   <= rem - CW'(1);
            state <= S_SPACE;
          end
        end

        // Send the spaces of one gap
        S_SPACE: begin
          if (sp == '0) begin
            idx   <= idx + CW'(1);
            state <= S_SEND;
          end else if (emit_ok) begin
            sp <= sp - CW'(1);
          end
        end

        // Send the newline and continue where the send was called from
        S_NL: begin
          if (emit_ok) begin
            wc      <= '0;
            letters <= '0;
            if (s_word) begin
              word_length <= '0;
              word_ovf    <= 1'b0;
            end
            unique case (ret)
              RET_WORD: begin
                idx    <= '0;
                slen   <= wlen;
                slack  <= '0;
                rem    <= '0;
                s_word <= 1'b1;
                s_last <= 1'b1;
                ret    <= RET_IDLE;
                state  <= S_SEND;
              end
              RET_COPY: begin
                idx      <= '0;
                cpos     <= '0;
                need_sep <= 1'b0;
                state    <= S_COPY;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
